/* rtl/core/frg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_pkg
// Shared width constants, divider handshake types and sign-magnitude helpers
// for the fraction reduction block.
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  go;
    word_t dividend;
    word_t divisor;
  } frg_div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
    word_t rem;
  } frg_div_rsp_t;

  // two's complement word to magnitude
  function automatic word_t to_mag(input word_t x);
    word_t m;
    m = x[DATA_WIDTH-1] ? (~x + word_t'(1)) : x;
    return m;
  endfunction

  // sign and magnitude back to two's complement
  function automatic word_t from_sm(input logic neg, input word_t mag);
    word_t r;
    r = neg ? (~mag + word_t'(1)) : mag;
    return r;
  endfunction

endpackage

/* rtl/core/frg_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_divider
// Unsigned restoring divider, one quotient bit per cycle. Gives quotient and
// remainder of two magnitudes; the divisor is never zero when started.
// ----------------------------------------------------------------------------
module frg_divider
  import frg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  frg_div_req_t req,
  output frg_div_rsp_t rsp
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  word_t            quo;
  word_t            rem;
  word_t            dvs;
  logic             done;

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  always_comb begin
    shifted = {rem, quo[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_WIDTH - 1);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[DATA_WIDTH-2:0], fits};
        rem <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held longer than one cycle");

  a_go_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    req.go |-> (req.divisor != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

/* rtl/core/fraction_reduce_gcd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_gcd
// Reduces a signed fraction to lowest terms: Euclidean remainder loop with
// truncating remainders, then exact division of both parts by the divisor.
//
// channel   handshake          payload
// input     start / busy       num_in, den_in
// result    done (one cycle)   num_out, den_out, div_zero
//
// all divisions run one after another on the shared divider
// a transaction does k remainder steps, then one exact division for each part
// (k up to about 46 at 32 bits)
// a zero denominator answers in the next cycle with div_zero set
// synchronous reset returns to idle; the receiver cannot stall results
// ----------------------------------------------------------------------------
module fraction_reduce_gcd
  import frg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] num_in,
  input  logic signed [DATA_WIDTH-1:0] den_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] num_out,
  output logic signed [DATA_WIDTH-1:0] den_out,
  output logic                         div_zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GCD,
    S_QN,
    S_QD
  } state_t;

  state_t       state;
  logic         n_neg;
  logic         d_neg;
  word_t        n_mag;
  word_t        d_mag;
  logic         x_neg;
  logic         y_neg;
  word_t        x_mag;
  word_t        y_mag;
  logic         div_go;
  frg_div_req_t div_req;
  frg_div_rsp_t div_rsp;

  word_t        in_n_mag;
  word_t        in_d_mag;
  logic         q_neg_n;
  logic         q_neg_d;

  always_comb begin
    in_n_mag = to_mag(word_t'(num_in));
    in_d_mag = to_mag(word_t'(den_in));
    q_neg_n  = (n_neg != y_neg) && (div_rsp.quo != '0);
    q_neg_d  = (d_neg != y_neg) && (div_rsp.quo != '0);
  end

  assign busy             = (state != S_IDLE);
  assign div_req.go       = div_go;
  assign div_req.dividend = x_mag;
  assign div_req.divisor  = y_mag;

  frg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n_neg <= num_in[DATA_WIDTH-1];
            n_mag <= in_n_mag;
            d_neg <= den_in[DATA_WIDTH-1];
            d_mag <= in_d_mag;
            if (in_d_mag == '0) begin
              done     <= 1'b1;
              div_zero <= 1'b1;
              num_out  <= '0;
              den_out  <= '0;
            end else begin
              x_neg  <= num_in[DATA_WIDTH-1];
              x_mag  <= in_n_mag;
              y_neg  <= den_in[DATA_WIDTH-1];
              y_mag  <= in_d_mag;
              div_go <= 1'b1;
              state  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (div_rsp.done) begin
            div_go <= 1'b1;
            if (div_rsp.rem == '0) begin
              x_mag <= n_mag;
              state <= S_QN;
            end else begin
              x_mag <= y_mag;
              x_neg <= y_neg;
              y_mag <= div_rsp.rem;
              y_neg <= x_neg;
            end
          end
        end
        S_QN: begin
          if (div_rsp.done) begin
            num_out <= from_sm(q_neg_n, div_rsp.quo);
            x_mag   <= d_mag;
            div_go  <= 1'b1;
            state   <= S_QD;
          end
        end
        S_QD: begin
          if (div_rsp.done) begin
            den_out  <= from_sm(q_neg_d, div_rsp.quo);
            div_zero <= 1'b0;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_zero_den_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (den_in == '0)) |=> (done && div_zero))
    else $error("zero denominator not flagged");

  a_zero_den_outputs: assert property (@(posedge clk) disable iff (rst)
    (done && div_zero) |-> ((num_out == '0) && (den_out == '0)))
    else $error("error result carries nonzero fields");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !div_zero) |-> (den_out != '0))
    else $error("reduced denominator is zero");
`endif

endmodule
